@@ design/dsu_pkg.sv @@
// shared types and constants of the union-find engine
package dsu_pkg;

   // fixed field widths of the stream beats
   localparam int ELEM_W     = 10;
   localparam int SIZE_W     = 11;
   localparam int KIND_W     = 2;
   localparam int WRAP_CNT_W = 4;

   // operation codes carried in req_tuser
   typedef enum logic [KIND_W-1:0] {
      OP_MAKE_SET = 2'd0,
      OP_UNION    = 2'd1,
      OP_FIND     = 2'd2
   } op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_DISPATCH,
      ST_WALK,
      ST_COMP,
      ST_LINK_WIN,
      ST_LINK_LOSE,
      ST_DONE
   } state_type;

   // one request beat, unpacked
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ELEM_W-1:0] elem_a;
      logic [ELEM_W-1:0] elem_b;
   } req_type;

   // one result beat, unpacked
   typedef struct packed {
      logic [ELEM_W-1:0] root;
      logic [SIZE_W-1:0] set_size;
      logic              merged;
   } res_type;

endpackage

@@ design/disjoint_set_union_find_unit.sv @@
// top level of the union-find engine: stream ports, table ram and result register
//
// Disjoint-set engine over NUM_ELEMENTS entries, union by size with full path
// compression. After reset the table is swept to all singletons, one entry per
// cycle, so req_tready stays low until the sweep ends. Each request beat
// gives exactly one response beat. One operation is in flight at a time and
// its cost is set by the single table read port, one link per cycle: make_set
// writes one singleton entry, find walks to the root and then makes a rewrite
// pass over the same path, and a union walks and rewrites both paths and then
// links the two roots, unless both elements already share a root. The engine
// holds the response in its done state while the output register is full,
// then returns to idle before the next request beat is taken. With union by
// size, path lengths stay near log2 of the set size. When NUM_ELEMENTS is
// below 1024 the indices are first reduced modulo the table size by a
// shift-and-subtract pass. The next request is taken while an earlier
// response still waits on rsp_tready.
module disjoint_set_union_find_unit
   import dsu_pkg::*;
#(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // elem_a [9:0], elem_b [19:10], zero pad
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // root [9:0], set_size [20:10], merged [21], zero pad
);

   localparam int IDX_W   = $clog2(NUM_ELEMENTS);
   localparam int ENTRY_W = $clog2(NUM_ELEMENTS + 1) + 1;

   req_type             req;
   res_type             res;
   logic                start;
   logic                idle;
   logic                res_valid;
   logic                res_ready;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic                rsp_valid_ff;
   res_type             rsp_data_ff;

   // unpack the request beat
   assign req.kind   = req_tuser;
   assign req.elem_a = req_tdata[ELEM_W-1:0];
   assign req.elem_b = req_tdata[2*ELEM_W-1:ELEM_W];
   assign req_tready = idle;
   assign start      = req_tvalid && idle;

   dsu_ctrl #(
      .NUM_ELEMENTS (NUM_ELEMENTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start_i     (start),
      .req_i       (req),
      .idle_o      (idle),
      .res_valid_o (res_valid),
      .res_ready_i (res_ready),
      .res_o       (res),
      .ram_we_o    (ram_we),
      .ram_waddr_o (ram_waddr),
      .ram_wdata_o (ram_wdata),
      .ram_raddr_o (ram_raddr),
      .ram_rdata_i (ram_rdata)
   );

   dsu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register decouples the engine from the response side
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   // pack the response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.merged, rsp_data_ff.set_size, rsp_data_ff.root};

endmodule

@@ design/dsu_ram.sv @@
// generic simple dual-port ram with registered read
module dsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dsu_ctrl.sv @@
// sequencer for root walks, path compression, linking and table clearing
module dsu_ctrl
   import dsu_pkg::*;
#(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start_i,
   input  req_type                           req_i,
   output logic                              idle_o,
   output logic                              res_valid_o,
   input  logic                              res_ready_i,
   output res_type                           res_o,
   output logic                              ram_we_o,
   output logic [$clog2(NUM_ELEMENTS)-1:0]   ram_waddr_o,
   output logic [$clog2(NUM_ELEMENTS+1):0]   ram_wdata_o,
   output logic [$clog2(NUM_ELEMENTS)-1:0]   ram_raddr_o,
   input  logic [$clog2(NUM_ELEMENTS+1):0]   ram_rdata_i
);

   localparam int IDX_W     = $clog2(NUM_ELEMENTS);
   localparam int LINK_W    = $clog2(NUM_ELEMENTS + 1);
   localparam bit NEED_WRAP = NUM_ELEMENTS < (1 << ELEM_W);

   // highest shift k with NUM_ELEMENTS << k still inside the input range
   function automatic int wrap_top(input int n);
      int k;
      k = 0;
      for (int i = 0; i < ELEM_W; i++) begin
         if ((n << (i + 1)) < (1 << ELEM_W)) begin
            k = i + 1;
         end
      end
      return k;
   endfunction

   localparam int WRAP_TOP = wrap_top(NUM_ELEMENTS);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   op_type                 kind_ff, kind_in;
   logic [ELEM_W-1:0]      ea_ff, ea_in;
   logic [ELEM_W-1:0]      eb_ff, eb_in;
   logic [WRAP_CNT_W-1:0]  k_ff, k_in;
   logic                   side_ff, side_in;
   logic [IDX_W-1:0]       start_ff, start_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       root_ff, root_in;
   logic [IDX_W-1:0]       ra_ff, ra_in;
   logic [LINK_W-1:0]      sa_ff, sa_in;
   logic [LINK_W-1:0]      sb_ff, sb_in;
   logic [IDX_W-1:0]       win_ff, win_in;
   logic [IDX_W-1:0]       lose_ff, lose_in;
   res_type                res_ff, res_in;

   logic                   rd_is_root;
   logic [LINK_W-1:0]      rd_link;
   logic [IDX_W-1:0]       rd_next;
   logic [IDX_W-1:0]       ea_idx;
   logic [IDX_W-1:0]       eb_idx;
   logic [ELEM_W-1:0]      wrap_sub;
   logic [LINK_W:0]        size_sum;
   logic [LINK_W-1:0]      size_sat;

   // entry decode: top bit is the root flag, the rest size or parent
   assign rd_is_root = ram_rdata_i[LINK_W];
   assign rd_link    = ram_rdata_i[LINK_W-1:0];
   assign rd_next    = IDX_W'(rd_link);
   assign ea_idx     = IDX_W'(ea_ff);
   assign eb_idx     = IDX_W'(eb_ff);

   // one modular reduction step and the saturating size adder
   assign wrap_sub = ELEM_W'(NUM_ELEMENTS) << k_ff;
   assign size_sum = {1'b0, sa_ff} + {1'b0, sb_ff};
   assign size_sat = (size_sum > (LINK_W + 1)'(NUM_ELEMENTS)) ?
                     LINK_W'(NUM_ELEMENTS) : size_sum[LINK_W-1:0];

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      ea_ff    <= ea_in;
      eb_ff    <= eb_in;
      k_ff     <= k_in;
      side_ff  <= side_in;
      start_ff <= start_in;
      cur_ff   <= cur_in;
      root_ff  <= root_in;
      ra_ff    <= ra_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      win_ff   <= win_in;
      lose_ff  <= lose_in;
      res_ff   <= res_in;
   end

   // next state, ram control and result capture
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      kind_in     = kind_ff;
      ea_in       = ea_ff;
      eb_in       = eb_ff;
      k_in        = k_ff;
      side_in     = side_ff;
      start_in    = start_ff;
      cur_in      = cur_ff;
      root_in     = root_ff;
      ra_in       = ra_ff;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      win_in      = win_ff;
      lose_in     = lose_ff;
      res_in      = res_ff;
      ram_we_o    = 1'b0;
      ram_waddr_o = cur_ff;
      ram_wdata_o = '0;
      ram_raddr_o = cur_ff;

      case (state_ff)
         // sweep the table to all singletons after reset
         ST_CLEAR: begin
            ram_we_o    = 1'b1;
            ram_waddr_o = clr_ff;
            ram_wdata_o = {1'b1, LINK_W'(1)};
            if (clr_ff == IDX_W'(NUM_ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start_i) begin
               kind_in  = op_type'(req_i.kind);
               ea_in    = req_i.elem_a;
               eb_in    = req_i.elem_b;
               k_in     = WRAP_CNT_W'(WRAP_TOP);
               state_in = NEED_WRAP ? ST_WRAP : ST_DISPATCH;
            end
         end
         // restoring reduction of both indices, one shift per cycle
         ST_WRAP: begin
            if (ea_ff >= wrap_sub) begin
               ea_in = ea_ff - wrap_sub;
            end
            if (eb_ff >= wrap_sub) begin
               eb_in = eb_ff - wrap_sub;
            end
            if (k_ff == '0) begin
               state_in = ST_DISPATCH;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_DISPATCH: begin
            case (kind_ff)
               OP_MAKE_SET: begin
                  ram_we_o          = 1'b1;
                  ram_waddr_o       = ea_idx;
                  ram_wdata_o       = {1'b1, LINK_W'(1)};
                  res_in.root       = ELEM_W'(ea_idx);
                  res_in.set_size   = SIZE_W'(1);
                  res_in.merged     = 1'b0;
                  state_in          = ST_DONE;
               end
               default: begin
                  ram_raddr_o = ea_idx;
                  start_in    = ea_idx;
                  cur_in      = ea_idx;
                  side_in     = 1'b0;
                  state_in    = ST_WALK;
               end
            endcase
         end
         // follow parent links, one table read per cycle
         ST_WALK: begin
            if (rd_is_root) begin
               root_in = cur_ff;
               if (side_ff) begin
                  sb_in = rd_link;
               end else begin
                  sa_in = rd_link;
               end
               cur_in      = start_ff;
               ram_raddr_o = start_ff;
               state_in    = ST_COMP;
            end else begin
               cur_in      = rd_next;
               ram_raddr_o = rd_next;
            end
         end
         // second pass: repoint each node on the path at the root
         ST_COMP: begin
            if (cur_ff == root_ff || rd_is_root) begin
               if (side_ff) begin
                  state_in = ST_LINK_WIN;
               end else if (kind_ff == OP_UNION) begin
                  ra_in       = root_ff;
                  side_in     = 1'b1;
                  start_in    = eb_idx;
                  cur_in      = eb_idx;
                  ram_raddr_o = eb_idx;
                  state_in    = ST_WALK;
               end else begin
                  res_in.root     = ELEM_W'(root_ff);
                  res_in.set_size = SIZE_W'(sa_ff);
                  res_in.merged   = 1'b0;
                  state_in        = ST_DONE;
               end
            end else begin
               ram_we_o    = 1'b1;
               ram_waddr_o = cur_ff;
               ram_wdata_o = {1'b0, LINK_W'(root_ff)};
               cur_in      = rd_next;
               ram_raddr_o = rd_next;
            end
         end
         // larger set wins, ties go to the second root
         ST_LINK_WIN: begin
            if (ra_ff == root_ff) begin
               res_in.root     = ELEM_W'(ra_ff);
               res_in.set_size = SIZE_W'(sa_ff);
               res_in.merged   = 1'b0;
               state_in        = ST_DONE;
            end else begin
               ram_we_o    = 1'b1;
               ram_wdata_o = {1'b1, size_sat};
               if (sa_ff > sb_ff) begin
                  ram_waddr_o = ra_ff;
                  win_in      = ra_ff;
                  lose_in     = root_ff;
               end else begin
                  ram_waddr_o = root_ff;
                  win_in      = root_ff;
                  lose_in     = ra_ff;
               end
               res_in.set_size = SIZE_W'(size_sat);
               res_in.merged   = 1'b1;
               state_in        = ST_LINK_LOSE;
            end
         end
         ST_LINK_LOSE: begin
            ram_we_o    = 1'b1;
            ram_waddr_o = lose_ff;
            ram_wdata_o = {1'b0, LINK_W'(win_ff)};
            res_in.root = ELEM_W'(win_ff);
            state_in    = ST_DONE;
         end
         // hold the result until the output register takes it
         ST_DONE: begin
            if (res_ready_i) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle_o      = (state_ff == ST_IDLE);
   assign res_valid_o = (state_ff == ST_DONE);
   assign res_o       = res_ff;

   // a new operation only starts from idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> state_ff == ST_IDLE)
      else $error("operation started while busy");

   // compression never reads the entry it rewrites in the same cycle
   a_comp_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && ram_we_o) |-> ram_waddr_o != ram_raddr_o)
      else $error("read and write of one entry in the same cycle");

   // only a union can report a merge
   a_merge_union: assert property (@(posedge clock) disable iff (reset)
      (res_valid_o && res_o.merged) |-> kind_ff == OP_UNION)
      else $error("merge reported for a non-union operation");

   // the clearing pass ends in idle
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && state_in != ST_CLEAR) |-> state_in == ST_IDLE)
      else $error("clearing pass left to a busy state");

endmodule
